>>> rtl/core/acpu_pkg.sv
// ----------------------------------------------------------------------------
// acpu_pkg
// Shared types, codes and decode helpers for the accumulator CPU step unit.
// ----------------------------------------------------------------------------
package acpu_pkg;

    // Memory geometry and the end of the ROM address region
    localparam int          MEM_BYTES = 256;
    localparam int          MEM_AW    = $clog2(MEM_BYTES);
    localparam logic [7:0]  ROM_END   = 8'd32;

    // Transaction actions
    localparam logic [1:0] ACT_LOAD    = 2'd0;
    localparam logic [1:0] ACT_STEP    = 2'd1;
    localparam logic [1:0] ACT_RESTART = 2'd2;

    // Run status codes
    localparam logic [1:0] ST_RUN  = 2'd0;
    localparam logic [1:0] ST_HALT = 2'd1;
    localparam logic [1:0] ST_ERR  = 2'd2;

    // Jump class and jump opcodes
    localparam logic [3:0] CLS_JUMP = 4'h1;
    localparam logic [7:0] OP_JMP   = 8'h10;
    localparam logic [7:0] OP_JMPN  = 8'h11;
    localparam logic [7:0] OP_JMPZ  = 8'h12;

    // Addressing mode, opcode bits [7:6]
    localparam logic [1:0] MD_IMM = 2'b00;
    localparam logic [1:0] MD_DIR = 2'b01;
    localparam logic [1:0] MD_BAD = 2'b10;
    localparam logic [1:0] MD_IND = 2'b11;

    // Function nibble, opcode bits [3:0], group with bit 5 clear
    localparam logic [3:0] FN_LOAD  = 4'h0;
    localparam logic [3:0] FN_OUT   = 4'h1;
    localparam logic [3:0] FN_STORE = 4'h8;
    localparam logic [3:0] FN_INPUT = 4'h9;
    // Function nibble, group with bit 5 set
    localparam logic [3:0] FN_ADD   = 4'h0;
    localparam logic [3:0] FN_SUB   = 4'h1;
    localparam logic [3:0] FN_NAND  = 4'h2;

    // Decoded operation kind
    typedef logic [2:0] t_kind;
    localparam t_kind K_BAD   = 3'd0;
    localparam t_kind K_LOAD  = 3'd1;
    localparam t_kind K_ADD   = 3'd2;
    localparam t_kind K_SUB   = 3'd3;
    localparam t_kind K_NAND  = 3'd4;
    localparam t_kind K_OUT   = 3'd5;
    localparam t_kind K_STORE = 3'd6;
    localparam t_kind K_INPUT = 3'd7;

    // One result transaction
    typedef struct packed {
        logic [1:0] status;
        logic [7:0] pc;
        logic [7:0] acc;
        logic       ov;
        logic [7:0] oval;
    } t_result;

    // Operand-taking opcode decode; jumps are handled separately
    function automatic t_kind op_kind(input logic [7:0] op);
        t_kind kind;
        logic  imm;
        kind = K_BAD;
        imm  = (op[7:6] == MD_IMM);
        if (!op[4] && (op[7:6] != MD_BAD)) begin
            if (!op[5]) begin
                unique case (op[3:0])
                    FN_LOAD:  kind = K_LOAD;
                    FN_OUT:   kind = imm ? K_BAD : K_OUT;
                    FN_STORE: kind = imm ? K_BAD : K_STORE;
                    FN_INPUT: kind = imm ? K_BAD : K_INPUT;
                    default:  kind = K_BAD;
                endcase
            end else begin
                unique case (op[3:0])
                    FN_ADD:  kind = K_ADD;
                    FN_SUB:  kind = K_SUB;
                    FN_NAND: kind = K_NAND;
                    default: kind = K_BAD;
                endcase
            end
        end
        return kind;
    endfunction

    // Status after the PC has moved
    function automatic logic [1:0] pc_status(input logic [7:0] pc);
        logic [1:0] st;
        priority if (pc == 8'd0) begin
            st = ST_HALT;
        end else if (pc < ROM_END) begin
            st = ST_ERR;
        end else begin
            st = ST_RUN;
        end
        return st;
    endfunction

endpackage

>>> rtl/core/acpu_ram.sv
// ----------------------------------------------------------------------------
// acpu_ram
// Generic synchronous RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module acpu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    // Storage array and read register
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_q <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_q;

endmodule

>>> rtl/core/accumulator_cpu_step_unit.sv
// ----------------------------------------------------------------------------
// accumulator_cpu_step_unit
// 8-bit accumulator machine, one instruction per step transaction, with its
// 256-byte memory in a single-port-per-cycle RAM and a small sequencer.
// ----------------------------------------------------------------------------
// Path per transaction: load, restart or idle step go from S_IDLE to S_PUSH;
// bad opcode or untaken jump via S_OP; taken jump via S_OP, S_JMP; immediate
// or direct store via S_OP, S_OPD; direct read adds S_VAL; indirect store adds
// S_IND; double-indirect read adds S_IND, S_VAL. At most one memory access per
// cycle; a one-entry input buffer takes the next transaction while one runs.
// Reset: PC = 32, A = 0, status running; memory reads as zero via written flags.
module accumulator_cpu_step_unit
    import acpu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    // Input channel
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_action,
    input  logic [7:0] i_load_address,
    input  logic [7:0] i_load_value,
    input  logic [7:0] i_input_byte,
    // Result channel
    output logic       o_valid,
    input  logic       i_stall,
    output logic [1:0] o_status,
    output logic [7:0] o_program_counter,
    output logic [7:0] o_accumulator,
    output logic       o_out_valid,
    output logic [7:0] o_out_value
);

    // Sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_OP   = 3'd1;
    localparam logic [2:0] S_OPD  = 3'd2;
    localparam logic [2:0] S_JMP  = 3'd3;
    localparam logic [2:0] S_IND  = 3'd4;
    localparam logic [2:0] S_VAL  = 3'd5;
    localparam logic [2:0] S_PUSH = 3'd6;

    // Input buffer
    logic       r_buf_vld;
    logic [1:0] r_buf_action;
    logic [7:0] r_buf_la;
    logic [7:0] r_buf_lv;
    logic [7:0] r_buf_inb;

    // Machine state
    logic [2:0] r_state, n_state;
    logic [7:0] r_pc, n_pc;
    logic [7:0] r_acc, n_acc;
    logic [1:0] r_status, n_status;
    logic [7:0] r_op, n_op;
    logic [7:0] r_inb, n_inb;
    logic       r_ov, n_ov;
    logic [7:0] r_oval, n_oval;

    // Result register
    logic    r_out_vld;
    t_result r_out;

    // Memory port
    logic                  mem_wr_en;
    logic [MEM_AW-1:0]     mem_wr_addr;
    logic [7:0]            mem_wr_data;
    logic                  mem_rd_en;
    logic [MEM_AW-1:0]     mem_rd_addr;
    logic [7:0]            ram_q;
    logic [MEM_BYTES-1:0]  r_mem_vld;
    logic                  r_rd_vld;
    logic [7:0]            mem_q;

    logic       buf_take;
    logic       out_free;
    logic       out_load;
    logic [7:0] pc1;
    logic [7:0] pc2;
    t_kind      kind_q;
    t_kind      kind_new;
    logic       jump_take;
    logic [7:0] exec_acc;
    logic       exec_ov;

    acpu_ram #(
        .WIDTH (8),
        .DEPTH (MEM_BYTES)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (ram_q)
    );

    // Never-written bytes read as zero
    assign mem_q = r_rd_vld ? ram_q : 8'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mem_vld <= '0;
            r_rd_vld  <= 1'b0;
        end else begin
            if (mem_wr_en) begin
                r_mem_vld[mem_wr_addr] <= 1'b1;
            end
            if (mem_rd_en) begin
                r_rd_vld <= r_mem_vld[mem_rd_addr];
            end
        end
    end

    // Input buffer: one transaction waits while another runs
    assign o_stall = r_buf_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf_vld <= 1'b0;
        end else if (i_valid && !o_stall) begin
            r_buf_vld <= 1'b1;
        end else if (buf_take) begin
            r_buf_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_buf_action <= i_action;
            r_buf_la     <= i_load_address;
            r_buf_lv     <= i_load_value;
            r_buf_inb    <= i_input_byte;
        end
    end

    // Decode and execute helpers
    assign pc1      = r_pc + 8'd1;
    assign pc2      = r_pc + 8'd2;
    assign kind_q   = op_kind(r_op);
    assign kind_new = op_kind(mem_q);
    assign jump_take = (mem_q == OP_JMP) ||
                       ((mem_q == OP_JMPN) && r_acc[7]) ||
                       ((mem_q == OP_JMPZ) && (r_acc == 8'd0));

    always_comb begin
        exec_acc = r_acc;
        exec_ov  = 1'b0;
        unique case (kind_q)
            K_LOAD:  exec_acc = mem_q;
            K_ADD:   exec_acc = r_acc + mem_q;
            K_SUB:   exec_acc = r_acc - mem_q;
            K_NAND:  exec_acc = ~(r_acc & mem_q);
            K_OUT:   exec_ov  = 1'b1;
            default: ;
        endcase
    end

    assign out_free = !r_out_vld || !i_stall;

    // Sequencer: at most one memory access per cycle
    always_comb begin
        n_state     = r_state;
        n_pc        = r_pc;
        n_acc       = r_acc;
        n_status    = r_status;
        n_op        = r_op;
        n_inb       = r_inb;
        n_ov        = r_ov;
        n_oval      = r_oval;
        buf_take    = 1'b0;
        out_load    = 1'b0;
        mem_wr_en   = 1'b0;
        mem_wr_addr = r_buf_la;
        mem_wr_data = r_buf_lv;
        mem_rd_en   = 1'b0;
        mem_rd_addr = r_pc;

        unique case (r_state)
            S_IDLE: begin
                if (r_buf_vld) begin
                    buf_take = 1'b1;
                    n_ov     = 1'b0;
                    n_oval   = 8'd0;
                    n_inb    = r_buf_inb;
                    n_state  = S_PUSH;
                    unique case (r_buf_action)
                        ACT_LOAD: begin
                            mem_wr_en = 1'b1;
                        end
                        ACT_STEP: begin
                            if (r_status == ST_RUN) begin
                                mem_rd_en = 1'b1;
                                n_state   = S_OP;
                            end
                        end
                        ACT_RESTART: begin
                            n_pc     = ROM_END;
                            n_acc    = 8'd0;
                            n_status = ST_RUN;
                        end
                        default: ;
                    endcase
                end
            end
            S_OP: begin
                n_op = mem_q;
                if (mem_q[7:4] == CLS_JUMP) begin
                    if (jump_take) begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = pc1;
                        n_state     = S_JMP;
                    end else begin
                        n_pc     = pc2;
                        n_status = pc_status(pc2);
                        n_state  = S_PUSH;
                    end
                end else if (kind_new == K_BAD) begin
                    n_pc     = pc1;
                    n_status = ST_ERR;
                    n_state  = S_PUSH;
                end else begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = pc1;
                    n_state     = S_OPD;
                end
            end
            S_JMP: begin
                n_pc     = mem_q;
                n_status = pc_status(mem_q);
                n_state  = S_PUSH;
            end
            S_OPD: begin
                if (r_op[7:6] == MD_IMM) begin
                    n_acc    = exec_acc;
                    n_ov     = exec_ov;
                    n_oval   = exec_ov ? mem_q : 8'd0;
                    n_pc     = pc2;
                    n_status = pc_status(pc2);
                    n_state  = S_PUSH;
                end else if ((r_op[7:6] == MD_DIR) &&
                             ((kind_q == K_STORE) || (kind_q == K_INPUT))) begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = mem_q;
                    mem_wr_data = (kind_q == K_STORE) ? r_acc : r_inb;
                    n_pc        = pc2;
                    n_status    = pc_status(pc2);
                    n_state     = S_PUSH;
                end else begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = mem_q;
                    n_state     = (r_op[7:6] == MD_DIR) ? S_VAL : S_IND;
                end
            end
            S_IND: begin
                if ((kind_q == K_STORE) || (kind_q == K_INPUT)) begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = mem_q;
                    mem_wr_data = (kind_q == K_STORE) ? r_acc : r_inb;
                    n_pc        = pc2;
                    n_status    = pc_status(pc2);
                    n_state     = S_PUSH;
                end else begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = mem_q;
                    n_state     = S_VAL;
                end
            end
            S_VAL: begin
                n_acc    = exec_acc;
                n_ov     = exec_ov;
                n_oval   = exec_ov ? mem_q : 8'd0;
                n_pc     = pc2;
                n_status = pc_status(pc2);
                n_state  = S_PUSH;
            end
            S_PUSH: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pc     <= ROM_END;
            r_acc    <= 8'd0;
            r_status <= ST_RUN;
        end else begin
            r_state  <= n_state;
            r_pc     <= n_pc;
            r_acc    <= n_acc;
            r_status <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op   <= n_op;
        r_inb  <= n_inb;
        r_ov   <= n_ov;
        r_oval <= n_oval;
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_load) begin
            r_out_vld <= 1'b1;
        end else if (!i_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out.status <= r_status;
            r_out.pc     <= r_pc;
            r_out.acc    <= r_acc;
            r_out.ov     <= r_ov;
            r_out.oval   <= r_oval;
        end
    end

    assign o_valid           = r_out_vld;
    assign o_status          = r_out.status;
    assign o_program_counter = r_out.pc;
    assign o_accumulator     = r_out.acc;
    assign o_out_valid       = r_out.ov;
    assign o_out_value       = r_out.oval;

`ifndef ASSERT_OFF
    // Read and write never share the memory port in one cycle
    a_port_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mem_wr_en && mem_rd_en))
        else $error("memory read and write in the same cycle");

    // An instruction in flight only runs with the machine running
    a_run_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE && r_state != S_PUSH) |-> (r_status == ST_RUN))
        else $error("instruction sequencing while not running");

    // Every read is consumed by a state that uses the read data
    a_rd_use: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_rd_en |=> (r_state == S_OP || r_state == S_OPD || r_state == S_JMP ||
                       r_state == S_IND || r_state == S_VAL))
        else $error("memory read data not consumed");

    // A result is only loaded when the output slot is free
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> (!r_out_vld || !i_stall))
        else $error("result register overwritten");
`endif

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the accumulator CPU step unit. A behavioural copy
// of the machine predicts every result transaction; short directed programs
// cover halting, ROM faults, bad opcodes and PC wrap, then random programs
// and raw noise run under random gaps and back-pressure on both channels.
// ----------------------------------------------------------------------------
module tb_top
    import acpu_pkg::*;
();

    // Bench-only codes
    localparam logic [1:0] ACT_NONE = 2'd3;

    localparam logic [7:0] OPC_LDI   = 8'h00;
    localparam logic [7:0] OPC_LDD   = 8'h40;
    localparam logic [7:0] OPC_LDX   = 8'hC0;
    localparam logic [7:0] OPC_ADDI  = 8'h20;
    localparam logic [7:0] OPC_ADDD  = 8'h60;
    localparam logic [7:0] OPC_ADDX  = 8'hE0;
    localparam logic [7:0] OPC_SUBI  = 8'h21;
    localparam logic [7:0] OPC_SUBD  = 8'h61;
    localparam logic [7:0] OPC_SUBX  = 8'hE1;
    localparam logic [7:0] OPC_NANDI = 8'h22;
    localparam logic [7:0] OPC_NANDD = 8'h62;
    localparam logic [7:0] OPC_NANDX = 8'hE2;
    localparam logic [7:0] OPC_OUTD  = 8'h41;
    localparam logic [7:0] OPC_OUTX  = 8'hC1;
    localparam logic [7:0] OPC_STD   = 8'h48;
    localparam logic [7:0] OPC_STX   = 8'hC8;
    localparam logic [7:0] OPC_IND   = 8'h49;
    localparam logic [7:0] OPC_INX   = 8'hC9;
    localparam logic [7:0] OPC_BAD   = 8'h33;

    localparam int PROGRAM_ITEMS = 360;
    localparam int NOISE_ITEMS   = 40;
    localparam int IDLE_LIMIT    = 2000;
    localparam int DRAIN_CYCLES  = 20;

    // DUT signals
    logic       i_clk          = 1'b0;
    logic       i_rst_n        = 1'b0;
    logic       i_valid        = 1'b0;
    logic       o_stall;
    logic [1:0] i_action       = ACT_NONE;
    logic [7:0] i_load_address = 8'd0;
    logic [7:0] i_load_value   = 8'd0;
    logic [7:0] i_input_byte   = 8'd0;
    logic       o_valid;
    logic       i_stall        = 1'b0;
    logic [1:0] o_status;
    logic [7:0] o_program_counter;
    logic [7:0] o_accumulator;
    logic       o_out_valid;
    logic [7:0] o_out_value;

    // Machine copy used for prediction
    logic [7:0] cpu_mem [MEM_BYTES];
    logic [7:0] cpu_pc;
    logic [7:0] cpu_acc;
    logic [1:0] cpu_status;

    t_result    pending_results[$];
    t_result    oldest;
    bit         idle_on = 1'b1;
    int         stall_left;
    int         idle_cycles;
    int         n_items, n_steps, n_outputs, n_halts, n_faults;
    int         n_checked, n_fail;

    accumulator_cpu_step_unit uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_action          (i_action),
        .i_load_address    (i_load_address),
        .i_load_value      (i_load_value),
        .i_input_byte      (i_input_byte),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_status          (o_status),
        .o_program_counter (o_program_counter),
        .o_accumulator     (o_accumulator),
        .o_out_valid       (o_out_valid),
        .o_out_value       (o_out_value)
    );

    always #5 i_clk = ~i_clk;

    // Gap length: mostly none, some short, a few long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        return $urandom_range(6, 24);
    endfunction

    // Apply one transaction to the machine copy and return its result
    function automatic t_result cpu_apply(input logic [1:0] act, input logic [7:0] la,
                                          input logic [7:0] lv, input logic [7:0] ib);
        t_result    r;
        logic [7:0] op;
        logic [7:0] opd;
        logic [7:0] val;
        logic       take;
        logic       bad;
        r.ov   = 1'b0;
        r.oval = 8'd0;
        bad    = 1'b0;
        case (act)
            ACT_LOAD: begin
                cpu_mem[la] = lv;
            end
            ACT_STEP: begin
                if (cpu_status == ST_RUN) begin
                    op     = cpu_mem[cpu_pc];
                    cpu_pc = cpu_pc + 8'd1;
                    if (op[7:4] == CLS_JUMP) begin
                        take = (op == OP_JMP) || (op == OP_JMPN && cpu_acc[7]) ||
                               (op == OP_JMPZ && cpu_acc == 8'd0);
                        cpu_pc = take ? cpu_mem[cpu_pc] : cpu_pc + 8'd1;
                    end else begin
                        opd = cpu_mem[cpu_pc];
                        case (op[7:6])
                            MD_IMM:  val = opd;
                            MD_DIR:  val = cpu_mem[opd];
                            MD_IND:  val = cpu_mem[cpu_mem[opd]];
                            default: val = 8'd0;
                        endcase
                        case (op)
                            OPC_LDI, OPC_LDD, OPC_LDX:       cpu_acc = val;
                            OPC_ADDI, OPC_ADDD, OPC_ADDX:    cpu_acc = cpu_acc + val;
                            OPC_SUBI, OPC_SUBD, OPC_SUBX:    cpu_acc = cpu_acc - val;
                            OPC_NANDI, OPC_NANDD, OPC_NANDX: cpu_acc = ~(cpu_acc & val);
                            OPC_OUTD, OPC_OUTX: begin
                                r.ov   = 1'b1;
                                r.oval = val;
                            end
                            OPC_STD: cpu_mem[opd]          = cpu_acc;
                            OPC_STX: cpu_mem[cpu_mem[opd]] = cpu_acc;
                            OPC_IND: cpu_mem[opd]          = ib;
                            OPC_INX: cpu_mem[cpu_mem[opd]] = ib;
                            default: bad = 1'b1;
                        endcase
                        if (bad) begin
                            cpu_status = ST_ERR;
                            n_faults++;
                        end else begin
                            cpu_pc = cpu_pc + 8'd1;
                        end
                    end
                    // PC landing on 0 halts; anywhere else in ROM is a fault
                    if (!bad) begin
                        if (cpu_pc == 8'd0) begin
                            cpu_status = ST_HALT;
                            n_halts++;
                        end else if (cpu_pc < ROM_END) begin
                            cpu_status = ST_ERR;
                            n_faults++;
                        end
                    end
                end
            end
            ACT_RESTART: begin
                cpu_pc     = ROM_END;
                cpu_acc    = 8'd0;
                cpu_status = ST_RUN;
            end
            default: ;
        endcase
        r.status = cpu_status;
        r.pc     = cpu_pc;
        r.acc    = cpu_acc;
        return r;
    endfunction

    // Random opcode from the operand-taking instruction set, jumps excluded
    function automatic logic [7:0] pick_opcode();
        case ($urandom_range(0, 17))
            0:       return OPC_LDI;
            1:       return OPC_LDD;
            2:       return OPC_LDX;
            3:       return OPC_ADDI;
            4:       return OPC_ADDD;
            5:       return OPC_ADDX;
            6:       return OPC_SUBI;
            7:       return OPC_SUBD;
            8:       return OPC_SUBX;
            9:       return OPC_NANDI;
            10:      return OPC_NANDD;
            11:      return OPC_NANDX;
            12:      return OPC_OUTD;
            13:      return OPC_OUTX;
            14:      return OPC_STD;
            15:      return OPC_STX;
            16:      return OPC_IND;
            default: return OPC_INX;
        endcase
    endfunction

    // Send one transaction, optionally after a gap; valid stays high afterwards
    task automatic send_item(input logic [1:0] act, input logic [7:0] la,
                             input logic [7:0] lv, input logic [7:0] ib);
        int gap;
        gap = idle_on ? gap_len() : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_action       <= act;
        i_load_address <= la;
        i_load_value   <= lv;
        i_input_byte   <= ib;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pending_results.push_back(cpu_apply(act, la, lv, ib));
        n_items++;
        if (act == ACT_STEP) n_steps++;
    endtask

    task automatic report_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            n_fail++;
        end
    endtask

    // Ignored action and a first step straight out of reset
    task automatic test_reset_and_ignore();
        send_item(ACT_NONE, 8'hFF, 8'hFF, 8'hFF);
        send_item(ACT_STEP, 8'h00, 8'h00, 8'h00);
        send_item(ACT_LOAD, 8'h00, 8'hFF, 8'h00);
    endtask

    // Input/output at extremes, halt, step while halted, ROM fault, bad opcode, PC wrap
    task automatic test_special_cases();
        send_item(ACT_RESTART, 8'($urandom), 8'($urandom), 8'($urandom));
        send_item(ACT_LOAD, 8'd32, OPC_IND, 8'h00);
        send_item(ACT_LOAD, 8'd33, 8'hFF, 8'h00);
        send_item(ACT_STEP, 8'h00, 8'h00, 8'hFF);
        send_item(ACT_LOAD, 8'd34, OPC_OUTD, 8'h00);
        send_item(ACT_LOAD, 8'd35, 8'hFF, 8'h00);
        send_item(ACT_STEP, 8'hFF, 8'hFF, 8'h00);
        send_item(ACT_LOAD, 8'd36, OP_JMP, 8'h00);
        send_item(ACT_LOAD, 8'd37, 8'h00, 8'h00);
        send_item(ACT_STEP, 8'h00, 8'h00, 8'h00);
        send_item(ACT_STEP, 8'h00, 8'h00, 8'h00);
        // jump into ROM
        send_item(ACT_RESTART, 8'h00, 8'h00, 8'h00);
        send_item(ACT_LOAD, 8'd33, 8'd5, 8'h00);
        send_item(ACT_LOAD, 8'd32, OP_JMP, 8'h00);
        send_item(ACT_STEP, 8'h00, 8'h00, 8'h00);
        // unknown opcode
        send_item(ACT_RESTART, 8'h00, 8'h00, 8'h00);
        send_item(ACT_LOAD, 8'd32, OPC_BAD, 8'h00);
        send_item(ACT_STEP, 8'h00, 8'h00, 8'h00);
        // PC runs off the top of memory and wraps to 0
        send_item(ACT_RESTART, 8'h00, 8'h00, 8'h00);
        send_item(ACT_LOAD, 8'd32, OP_JMP, 8'h00);
        send_item(ACT_LOAD, 8'd33, 8'hFE, 8'h00);
        send_item(ACT_STEP, 8'h00, 8'h00, 8'h00);
        send_item(ACT_STEP, 8'h00, 8'h00, 8'h00);
    endtask

    // Random, mostly well-formed programs loaded at ROM_END, then stepped
    task automatic test_random_programs();
        int         k;
        int         n_ops;
        int         n_run;
        int         r;
        int         start_items;
        logic [7:0] op;
        logic [7:0] arg;
        start_items = n_items;
        while (n_items - start_items < PROGRAM_ITEMS) begin
            idle_on = ($urandom_range(0, 3) != 0);
            n_ops   = $urandom_range(3, 10);
            for (k = 0; k < n_ops; k++) begin
                r = $urandom_range(0, 99);
                if (r < 8) begin
                    op  = 8'($urandom);
                    arg = 8'($urandom);
                end else if (r < 24) begin
                    case ($urandom_range(0, 2))
                        0:       op = OP_JMP;
                        1:       op = OP_JMPN;
                        default: op = OP_JMPZ;
                    endcase
                    r = $urandom_range(0, 15);
                    if (r == 0) arg = 8'd0;
                    else if (r < 3) arg = 8'($urandom);
                    else arg = 8'(ROM_END + 2 * $urandom_range(0, n_ops));
                end else begin
                    op  = pick_opcode();
                    // keep most data traffic clear of the program
                    arg = ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                      : 8'($urandom_range(128, 255));
                end
                send_item(ACT_LOAD, 8'(ROM_END + 2 * k), op, 8'($urandom));
                send_item(ACT_LOAD, 8'(ROM_END + 2 * k + 1), arg, 8'($urandom));
            end
            repeat ($urandom_range(1, 4))
                send_item(ACT_LOAD, 8'($urandom_range(128, 255)), 8'($urandom),
                          8'($urandom));
            send_item(ACT_RESTART, 8'($urandom), 8'($urandom), 8'($urandom));
            n_run = n_ops + $urandom_range(1, 6);
            repeat (n_run) begin
                if ($urandom_range(0, 19) == 0)
                    send_item(2'($urandom_range(0, 3)), 8'($urandom), 8'($urandom),
                              8'($urandom));
                send_item(ACT_STEP, 8'($urandom), 8'($urandom), 8'($urandom));
            end
        end
    endtask

    // Fully random transactions, any action, any address
    task automatic test_noise();
        idle_on = 1'b1;
        repeat (NOISE_ITEMS)
            send_item(2'($urandom_range(0, 3)), 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    // Result-side back-pressure
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
            if (idle_on && $urandom_range(0, 2) == 0) stall_left = gap_len();
        end
    end

    // Result checker: oldest prediction against each accepted result
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            n_checked++;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual status %0d pc %0d",
                         $time, o_status, o_program_counter);
                n_fail++;
            end else begin
                oldest = pending_results.pop_front();
                report_field("status",          oldest.status, o_status);
                report_field("program_counter", oldest.pc,     o_program_counter);
                report_field("accumulator",     oldest.acc,    o_accumulator);
                report_field("out_valid",       oldest.ov,     o_out_valid);
                report_field("out_value",       oldest.oval,   o_out_value);
                if (oldest.ov) n_outputs++;
            end
        end
    end

    // Watchdog on cycles with no transaction on either channel
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial begin
        for (int a = 0; a < MEM_BYTES; a++) cpu_mem[a] = 8'd0;
        cpu_pc     = ROM_END;
        cpu_acc    = 8'd0;
        cpu_status = ST_RUN;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_and_ignore();
        test_special_cases();
        test_random_programs();
        test_noise();

        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d transactions: %0d instruction steps, %0d outputs,",
                 n_items, n_steps, n_outputs);
        $display("%0d halts, %0d faults; compared %0d results, %0d field mismatches.",
                 n_halts, n_faults, n_checked, n_fail);
        if (n_fail == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
